// ===== rtl/escaped_frame_builder_top_macros.svh =====
// Assertion macros shared by the checker of the frame builder.
`ifndef ESCAPED_FRAME_BUILDER_TOP_MACROS_SVH
`define ESCAPED_FRAME_BUILDER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EFB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/efb_pkg.sv =====
package efb_pkg;

    localparam int MAX_FRAME_DEFAULT   = 128;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0] SYNC_CHAR   = 8'h24;
    localparam logic [7:0] ESC_CHAR    = 8'h21;
    localparam logic [7:0] ESC_SYNC    = 8'h30;
    localparam logic [7:0] ESC_ESC     = 8'h31;
    localparam logic [7:0] CMD_RESET   = 8'h35;
    localparam logic [7:0] CK_INVERT   = 8'hff;
    localparam logic [8:0] START_EXTRA = 9'd5;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_NO_FRAME = 2'd3;

    localparam int JOB_UNITS  = 5;
    localparam int UNIT_IDX_W = 3;

    typedef struct packed {
        logic       operation;
        logic [7:0] payload_byte;
        logic [7:0] channel;
        logic [7:0] payload_length;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last_of_run;
        logic       frame_done;
        logic [1:0] status;
    } result_t;

    // One source byte of a run; esc marks a byte that is byte-stuffed if it is a special character.
    typedef struct packed {
        logic       esc;
        logic [7:0] data;
    } unit_t;

    typedef struct packed {
        logic                   byte_valid;
        logic                   close;
        logic [1:0]             status_last;
        logic [UNIT_IDX_W-1:0]  last_idx;
        unit_t [JOB_UNITS-1:0]  units;
    } job_t;

    function automatic logic is_special(input logic [7:0] b);
        is_special = (b == SYNC_CHAR) || (b == ESC_CHAR);
    endfunction

    function automatic logic [8:0] esc_len(input logic [7:0] b);
        esc_len = is_special(b) ? 9'd2 : 9'd1;
    endfunction

endpackage

// ===== rtl/efb_front.sv =====
module efb_front #(
    parameter int MAX_FRAME = efb_pkg::MAX_FRAME_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic [7:0]    cfg_data,
    input  logic          accept,
    input  efb_pkg::item_t item,
    output efb_pkg::job_t  job
);

    localparam logic [8:0] MaxLimit = 9'(MAX_FRAME);

    logic [7:0] command_char_reg;
    logic       frame_open_reg, frame_open_next;
    logic [7:0] remaining_reg, remaining_next;
    logic [7:0] sum_reg, sum_next;
    logic [8:0] count_reg, count_next;

    always_comb
    begin
        logic [7:0] len2;
        logic [7:0] s;
        logic [7:0] ck;
        logic [7:0] rem1;
        logic [8:0] cnt;
        logic       close;

        job             = '0;
        frame_open_next = frame_open_reg;
        remaining_next  = remaining_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        len2  = item.payload_length + 8'd2;
        s     = '0;
        ck    = '0;
        rem1  = '0;
        cnt   = '0;
        close = 1'b0;

        if (item.operation == efb_pkg::OP_START)
        begin
            frame_open_next = 1'b0;
            remaining_next  = '0;
            sum_next        = '0;
            count_next      = '0;
            if ({1'b0, item.payload_length} + efb_pkg::START_EXTRA > MaxLimit)
            begin
                job.status_last = efb_pkg::ST_TOO_LONG;
            end
            else
            begin
                s     = command_char_reg + item.channel;
                ck    = s ^ efb_pkg::CK_INVERT;
                close = (item.payload_length == 8'd0);
                cnt   = 9'd2 + efb_pkg::esc_len(len2) + efb_pkg::esc_len(command_char_reg)
                        + (close ? efb_pkg::esc_len(ck) : 9'd0);
                job.byte_valid  = 1'b1;
                job.close       = close;
                job.status_last = (close && cnt > MaxLimit) ? efb_pkg::ST_OVERFLOW
                                                            : efb_pkg::ST_OK;
                job.last_idx    = close ? efb_pkg::UNIT_IDX_W'(4) : efb_pkg::UNIT_IDX_W'(3);
                job.units[0]    = '{esc: 1'b0, data: efb_pkg::SYNC_CHAR};
                job.units[1]    = '{esc: 1'b1, data: len2};
                job.units[2]    = '{esc: 1'b1, data: command_char_reg};
                job.units[3]    = '{esc: 1'b0, data: item.channel};
                job.units[4]    = '{esc: 1'b1, data: ck};
                frame_open_next = !close;
                remaining_next  = item.payload_length;
                sum_next        = s;
                count_next      = cnt;
            end
        end
        else if (!frame_open_reg)
        begin
            job.status_last = efb_pkg::ST_NO_FRAME;
        end
        else
        begin
            s     = sum_reg + item.payload_byte;
            ck    = s ^ efb_pkg::CK_INVERT;
            rem1  = remaining_reg - 8'd1;
            close = (rem1 == 8'd0);
            cnt   = count_reg + efb_pkg::esc_len(item.payload_byte)
                    + (close ? efb_pkg::esc_len(ck) : 9'd0);
            job.byte_valid  = 1'b1;
            job.close       = close;
            job.status_last = (close && cnt > MaxLimit) ? efb_pkg::ST_OVERFLOW
                                                        : efb_pkg::ST_OK;
            job.last_idx    = close ? efb_pkg::UNIT_IDX_W'(1) : efb_pkg::UNIT_IDX_W'(0);
            job.units[0]    = '{esc: 1'b1, data: item.payload_byte};
            job.units[1]    = '{esc: 1'b1, data: ck};
            frame_open_next = !close;
            remaining_next  = rem1;
            sum_next        = s;
            count_next      = cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_char_reg <= efb_pkg::CMD_RESET;
            frame_open_reg   <= 1'b0;
            remaining_reg    <= '0;
            sum_reg          <= '0;
            count_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                command_char_reg <= cfg_data;
            end
            if (accept)
            begin
                frame_open_reg <= frame_open_next;
                remaining_reg  <= remaining_next;
                sum_reg        <= sum_next;
                count_reg      <= count_next;
            end
        end
    end

endmodule

// ===== rtl/efb_queue.sv =====
module efb_queue #(
    parameter int DEPTH = efb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  efb_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output efb_pkg::job_t head
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    efb_pkg::job_t mem_reg [DEPTH];
    logic [IW-1:0] wr_ptr_reg;
    logic [IW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/efb_back.sv =====
module efb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  efb_pkg::job_t    head,
    input  logic             head_valid,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_stall,
    output efb_pkg::result_t result
);

    efb_pkg::job_t                  cur_reg, cur_next;
    logic                           busy_reg, busy_next;
    logic [efb_pkg::UNIT_IDX_W-1:0] idx_reg, idx_next;
    logic                           sec_reg, sec_next;
    logic                           out_valid_reg, out_valid_next;
    efb_pkg::result_t               out_reg, out_next;

    always_comb
    begin
        logic                           advance;
        logic                           go;
        efb_pkg::job_t                  job;
        logic [efb_pkg::UNIT_IDX_W-1:0] idx;
        logic                           sec;
        efb_pkg::unit_t                 unit;
        logic                           special;
        logic                           unit_end;
        logic                           run_end;
        logic [7:0]                     b;

        advance = !out_valid_reg || !result_stall;
        go      = advance && (busy_reg || head_valid);
        job     = busy_reg ? cur_reg : head;
        idx     = busy_reg ? idx_reg : '0;
        sec     = busy_reg && sec_reg;
        unit    = job.units[idx];
        special = unit.esc && efb_pkg::is_special(unit.data);
        if (sec)
        begin
            b = (unit.data == efb_pkg::SYNC_CHAR) ? efb_pkg::ESC_SYNC : efb_pkg::ESC_ESC;
        end
        else
        begin
            b = special ? efb_pkg::ESC_CHAR : unit.data;
        end
        unit_end = !special || sec;
        run_end  = unit_end && (idx == job.last_idx);

        pop            = advance && !busy_reg && head_valid;
        cur_next       = cur_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        sec_next       = sec_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (go)
        begin
            out_valid_next       = 1'b1;
            out_next.out_byte    = b;
            out_next.byte_valid  = job.byte_valid;
            out_next.last_of_run = run_end;
            out_next.frame_done  = run_end && job.close;
            out_next.status      = run_end ? job.status_last : efb_pkg::ST_OK;
            cur_next             = job;
            busy_next            = !run_end;
            idx_next             = unit_end ? idx + 1'b1 : idx;
            sec_next             = !unit_end;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            sec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            sec_reg       <= sec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

// ===== rtl/escaped_frame_builder_top.sv =====
// Channel   Handshake                     Payload
// item      item_valid / item_stall       efb_pkg::item_t
// result    result_valid / result_stall   efb_pkg::result_t
// config    cfg_write                     cfg_data (command character)
//
// The output register passes one result per cycle unless result_stall holds it. An item produces
// one result for an error report, one to four for a payload byte, up to seven for a start item.
// An accepted item's job is stored in the queue, then its first result in the output register.
// The job queue holds QUEUE_DEPTH items; item_stall is high only while it is full.
// Reset is asynchronous and active low; the command character resets to '5'.
module escaped_frame_builder_top #(
    parameter int MAX_FRAME   = efb_pkg::MAX_FRAME_DEFAULT,
    parameter int QUEUE_DEPTH = efb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [7:0]       cfg_data,
    input  logic             item_valid,
    output logic             item_stall,
    input  efb_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output efb_pkg::result_t result
);

    efb_pkg::job_t new_job;
    efb_pkg::job_t head_job;
    logic          q_full;
    logic          q_not_empty;
    logic          q_pop;
    logic          accept;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    efb_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (item),
        .job       (new_job)
    );

    efb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_job  (new_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_job)
    );

    efb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head_job),
        .head_valid   (q_not_empty),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ===== rtl/efb_checker.sv =====
`include "escaped_frame_builder_top_macros.svh"

module efb_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_stall,
    input efb_pkg::result_t result
);

    // A stalled result must stay on the port unchanged.
    `EFB_ASSERT_NEXT(a_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

    // The end of a frame always closes the run of its item.
    `EFB_ASSERT_SAME(a_done_last, clk, rst_n, result_valid && result.frame_done, result.last_of_run, "frame end not last of run")

    // A result without a frame byte is a lone error report.
    `EFB_ASSERT_SAME(a_err_alone, clk, rst_n, result_valid && !result.byte_valid, result.last_of_run && result.out_byte == 8'd0 && (result.status == efb_pkg::ST_TOO_LONG || result.status == efb_pkg::ST_NO_FRAME), "bad error result")

    // Overflow is reported only on the final byte of a frame.
    `EFB_ASSERT_SAME(a_ovf_done, clk, rst_n, result_valid && result.status == efb_pkg::ST_OVERFLOW, result.frame_done && result.byte_valid, "overflow outside frame end")

endmodule

bind escaped_frame_builder_top efb_checker u_checker (.*);
